FILE: src/ihss_pkg.sv
// ----------------------------------------------------------------------------
// ihss_pkg: shared types and constants for the image header size sniffer
// Format modes, JPEG segment walk phases, signature bytes and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package ihss_pkg;

  localparam logic [4:0] HEADER_BYTES = 5'd24;

  localparam logic [7:0] PNG_SIG0   = 8'h89;
  localparam logic [7:0] PNG_SIG1   = 8'h50;
  localparam logic [7:0] PNG_SIG2   = 8'h4E;
  localparam logic [7:0] PNG_SIG3   = 8'h47;
  localparam logic [7:0] JPG_MARKER = 8'hFF;
  localparam logic [7:0] JPG_SOI    = 8'hD8;
  localparam logic [7:0] SOF_FIRST  = 8'hC0;
  localparam logic [7:0] SOF_LAST   = 8'hCF;
  localparam logic [7:0] JPG_DHT    = 8'hC4;
  localparam logic [7:0] JPG_JPG    = 8'hC8;
  localparam logic [7:0] JPG_DAC    = 8'hCC;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_PNG       = 2'd1,
    MODE_JPEG      = 2'd2,
    MODE_DONE      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PNG  = 2'd1,
    KIND_JPEG = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    PH_MARKER   = 4'd0,
    PH_TYPE     = 4'd1,
    PH_LEN_HI   = 4'd2,
    PH_LEN_LO   = 4'd3,
    PH_SKIP     = 4'd4,
    PH_PREC     = 4'd5,
    PH_H_HI     = 4'd6,
    PH_H_LO     = 4'd7,
    PH_W_HI     = 4'd8,
    PH_W_LO     = 4'd9,
    PH_WAIT     = 4'd10
  } phase_e;

  // start-of-frame types: C0..CF except DHT, JPG and DAC
  function automatic logic is_frame_type(input logic [7:0] t);
    is_frame_type = (t >= SOF_FIRST) && (t <= SOF_LAST) &&
                    (t != JPG_DHT) && (t != JPG_JPG) && (t != JPG_DAC);
  endfunction

endpackage

`default_nettype wire

FILE: src/image_header_size_sniffer.sv
// ----------------------------------------------------------------------------
// image_header_size_sniffer: PNG / JPEG pixel dimension extractor
// Streams an image file one byte per word and returns one width/height/kind
// result per file.
// ----------------------------------------------------------------------------
// Takes one file byte per clock with no gaps needed: each byte updates a small
// parser state in the cycle it is accepted, and a result, when that byte
// decides one, is registered in the output stage before it shows on the master side.
// A two-entry output stage (result register plus skid register) lets input
// keep flowing while a result waits; s_axis_tready_o drops only when both
// entries hold results. PNG dimensions are reported on byte 23; a JPEG result
// goes out once the frame header is parsed and at least 24 bytes have arrived.
// Failure, unknown format or an early tlast gives kind 0 with zero size.
// After the result, bytes are dropped until tlast, which rearms the parser.
`default_nettype none

module image_header_size_sniffer
  import ihss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // [31:0] image_width, [63:32] image_height
  output logic [1:0]       m_axis_tuser_o    // [1:0] image_kind
);

  // parser state
  logic [4:0]  pos_q, pos_d;
  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [63:0] cap_q, cap_d;
  logic [7:0]  seg_kind_q, seg_kind_d;
  logic        pending_q, pending_d;
  logic        given_q, given_d;

  // output stage
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_w_q, out_w_d, out_h_q, out_h_d;
  kind_e       out_k_q, out_k_d;
  logic        skid_valid_q, skid_valid_d;
  logic [31:0] skid_w_q, skid_w_d, skid_h_q, skid_h_d;
  kind_e       skid_k_q, skid_k_d;

  logic        accept;
  logic        res_valid;
  logic [31:0] res_w, res_h;
  kind_e       res_k;
  logic [7:0]  b;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;

  always_comb begin
    pos_d      = pos_q;
    mode_d     = mode_q;
    phase_d    = phase_q;
    skip_d     = skip_q;
    cap_d      = cap_q;
    seg_kind_d = seg_kind_q;
    pending_d  = pending_q;
    given_d    = given_q;
    res_valid  = 1'b0;
    res_w      = '0;
    res_h      = '0;
    res_k      = KIND_NONE;

    if (accept) begin
      if (!given_q) begin
        if (!pending_q) begin
          cap_d = {cap_q[55:0], b};
          case (mode_q)
            MODE_UNDECIDED: begin
              if (pos_q == 5'd1) begin
                if (cap_q[7:0] == JPG_MARKER && b == JPG_SOI) begin
                  mode_d  = MODE_JPEG;
                  phase_d = PH_MARKER;
                end else if (!(cap_q[7:0] == PNG_SIG0 && b == PNG_SIG1)) begin
                  res_valid = 1'b1;
                end
              end else if (pos_q == 5'd2) begin
                if (b != PNG_SIG2) res_valid = 1'b1;
              end else if (pos_q == 5'd3) begin
                if (b == PNG_SIG3) mode_d = MODE_PNG;
                else res_valid = 1'b1;
              end else if (pos_q != 5'd0) begin
                res_valid = 1'b1;
              end
            end
            MODE_PNG: begin
              if (pos_q == HEADER_BYTES - 5'd1) begin
                res_valid = 1'b1;
                res_w     = cap_d[63:32];
                res_h     = cap_d[31:0];
                res_k     = KIND_PNG;
              end
            end
            MODE_JPEG: begin
              case (phase_q)
                PH_MARKER: begin
                  if (b != JPG_MARKER) res_valid = 1'b1;
                  else phase_d = PH_TYPE;
                end
                PH_TYPE: begin
                  seg_kind_d = b;
                  phase_d    = PH_LEN_HI;
                end
                PH_LEN_HI: phase_d = PH_LEN_LO;
                PH_LEN_LO: begin
                  if (is_frame_type(seg_kind_q)) begin
                    phase_d = PH_PREC;
                  end else if (cap_d[15:0] < 16'd2) begin
                    res_valid = 1'b1;
                  end else if (cap_d[15:0] == 16'd2) begin
                    phase_d = PH_MARKER;
                  end else begin
                    skip_d  = cap_d[15:0] - 16'd2;
                    phase_d = PH_SKIP;
                  end
                end
                PH_SKIP: begin
                  skip_d = skip_q - 16'd1;
                  if (skip_q == 16'd1) phase_d = PH_MARKER;
                end
                PH_PREC:  phase_d = PH_H_HI;
                PH_H_HI:  phase_d = PH_H_LO;
                PH_H_LO:  phase_d = PH_W_HI;
                PH_W_HI:  phase_d = PH_W_LO;
                PH_W_LO: begin
                  pending_d = 1'b1;
                  phase_d   = PH_WAIT;
                end
                default: res_valid = 1'b1;
              endcase
            end
            default: ;
          endcase
        end
        // frame header parsed; release once the header window is covered
        if (!res_valid && pending_d && pos_q >= HEADER_BYTES - 5'd1) begin
          res_valid = 1'b1;
          res_w     = {16'd0, cap_d[15:0]};
          res_h     = {16'd0, cap_d[31:16]};
          res_k     = KIND_JPEG;
        end
        if (res_valid) begin
          given_d   = 1'b1;
          pending_d = 1'b0;
          mode_d    = MODE_DONE;
        end
      end

      if (pos_q < HEADER_BYTES) pos_d = pos_q + 5'd1;

      if (s_axis_tlast_i) begin
        if (!res_valid && !given_q) begin
          res_valid = 1'b1;
          res_w     = '0;
          res_h     = '0;
          res_k     = KIND_NONE;
        end
        pos_d      = '0;
        mode_d     = MODE_UNDECIDED;
        phase_d    = PH_MARKER;
        skip_d     = '0;
        cap_d      = '0;
        seg_kind_d = '0;
        pending_d  = 1'b0;
        given_d    = 1'b0;
      end
    end
  end

  // output register with skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_w_d      = out_w_q;
    out_h_d      = out_h_q;
    out_k_d      = out_k_q;
    skid_valid_d = skid_valid_q;
    skid_w_d     = skid_w_q;
    skid_h_d     = skid_h_q;
    skid_k_d     = skid_k_q;
    if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_w_d      = skid_w_q;
        out_h_d      = skid_h_q;
        out_k_d      = skid_k_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_w_d     = res_w;
        out_h_d     = res_h;
        out_k_d     = res_k;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_w_d     = res_w;
      skid_h_d     = res_h;
      skid_k_d     = res_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      mode_q       <= MODE_UNDECIDED;
      phase_q      <= PH_MARKER;
      skip_q       <= '0;
      cap_q        <= '0;
      seg_kind_q   <= '0;
      pending_q    <= 1'b0;
      given_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      mode_q       <= mode_d;
      phase_q      <= phase_d;
      skip_q       <= skip_d;
      cap_q        <= cap_d;
      seg_kind_q   <= seg_kind_d;
      pending_q    <= pending_d;
      given_q      <= given_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_w_q  <= out_w_d;
    out_h_q  <= out_h_d;
    out_k_q  <= out_k_d;
    skid_w_q <= skid_w_d;
    skid_h_q <= skid_h_d;
    skid_k_q <= skid_k_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_h_q, out_w_q};
  assign m_axis_tuser_o  = out_k_q;

  // ---- assertions ----
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while output register is empty");

  a_fail_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_k_q == KIND_NONE) |-> (out_w_q == '0 && out_h_q == '0))
    else $error("failed result carries nonzero dimensions");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_valid && !s_axis_tlast_i) |=> given_q)
    else $error("result given without marking the file done");

  a_pending_jpeg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (mode_q == MODE_JPEG && phase_q == PH_WAIT))
    else $error("pending result outside the JPEG walk");

  a_given_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q |-> (mode_q == MODE_DONE && !pending_q))
    else $error("parser still active after its result");

endmodule

`default_nettype wire
